@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue: field widths, operation and status
// codes, sequencer states and the entry record. No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned PRI_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_QUERY  = 3'd2,
    KIND_POP    = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_NULL = 2'd1,
    STAT_FULL = 2'd2,
    STAT_MISS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_SHL_RD,
    S_SHL_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic id_eq;   // stored id equals the request id
    logic pri_lt;  // stored priority below the request priority
  } cmp_flags_t;

endpackage

@@ rtl/spq_if.sv @@
// Request and response channel interfaces for the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_in_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   object_id;
  logic [PRI_W-1:0]  priority_req;

  modport source (output valid, kind, object_id, priority_req, input ready);
  modport sink   (input valid, kind, object_id, priority_req, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_object;
  logic [PRI_W-1:0]    out_priority;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_object, out_priority, entry_count,
                  input ready);
  modport sink   (input valid, status, out_object, out_priority, entry_count,
                  output ready);
endinterface

@@ rtl/spq_mem.sv @@
// Entry store of the queue: one write port, one read port, registered read.
// Depends on spq_pkg for the entry record.
module spq_mem import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/spq_cmp.sv @@
// Shared compare unit: id equality and priority order of a stored entry
// against the request. Depends on spq_pkg.
module spq_cmp import spq_pkg::*; (
  input  entry_t     stored,
  input  entry_t     key,
  output cmp_flags_t flags
);

  assign flags.id_eq  = (stored.id == key.id);
  assign flags.pri_lt = (stored.pri < key.pri);

endmodule

@@ rtl/spq_seq.sv @@
// Sequencer of the queue: walks the entry store one slot per step for
// search, ordered insert and compaction, and holds the response register.
// Depends on spq_pkg and the channel interfaces.
module spq_seq import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  spq_in_if.sink                   in_req,
  spq_out_if.source                out_rsp,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output entry_t                   mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  entry_t                   mem_rdata,
  output entry_t                   cmp_key,
  input  cmp_flags_t               cmp_flags
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [PRI_W-1:0]    pri_r, pri_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  logic [ID_W-1:0]     pop_id_r, pop_id_nxt;
  logic [PRI_W-1:0]    pop_pri_r, pop_pri_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_object_r, out_object_nxt;
  logic [PRI_W-1:0]    out_priority_r, out_priority_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [CW-1:0]       pos_p1;
  logic [CW-1:0]       pos_m1;

  assign pos_p1  = pos_r + 1'b1;
  assign pos_m1  = pos_r - 1'b1;
  assign cmp_key = '{id: id_r, pri: pri_r};

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.out_object   = out_object_r;
  assign out_rsp.out_priority = out_priority_r;
  assign out_rsp.entry_count  = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r         <= kind_nxt;
    id_r           <= id_nxt;
    pri_r          <= pri_nxt;
    pos_r          <= pos_nxt;
    stat_r         <= stat_nxt;
    pop_id_r       <= pop_id_nxt;
    pop_pri_r      <= pop_pri_nxt;
    out_status_r   <= out_status_nxt;
    out_object_r   <= out_object_nxt;
    out_priority_r <= out_priority_nxt;
    out_count_r    <= out_count_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    id_nxt           = id_r;
    pri_nxt          = pri_r;
    count_nxt        = count_r;
    pos_nxt          = pos_r;
    stat_nxt         = stat_r;
    pop_id_nxt       = pop_id_r;
    pop_pri_nxt      = pop_pri_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_object_nxt   = out_object_r;
    out_priority_nxt = out_priority_r;
    out_count_nxt    = out_count_r;
    mem_we           = 1'b0;
    mem_waddr        = pos_r[AW-1:0];
    mem_wdata        = mem_rdata;
    mem_raddr        = pos_r[AW-1:0];

    // Drop the response once it is taken.
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt    = in_req.kind;
          id_nxt      = in_req.object_id;
          pri_nxt     = in_req.priority_req;
          pop_id_nxt  = '0;
          pop_pri_nxt = '0;
          stat_nxt    = STAT_OK;
          state_nxt   = S_RESP;
          if ((in_req.kind == KIND_INSERT || in_req.kind == KIND_REMOVE ||
               in_req.kind == KIND_QUERY) && in_req.object_id == '0) begin
            stat_nxt = STAT_NULL;
          end else begin
            case (in_req.kind)
              KIND_INSERT: begin
                if (count_r == DEPTH_C) begin
                  stat_nxt = STAT_FULL;
                end else if (count_r == '0) begin
                  pos_nxt   = '0;
                  state_nxt = S_INS_PUT;
                end else begin
                  pos_nxt   = count_r;
                  state_nxt = S_INS_RD;
                end
              end
              KIND_REMOVE, KIND_QUERY, KIND_POP: begin
                if (count_r == '0) begin
                  stat_nxt = STAT_MISS;
                end else begin
                  pos_nxt   = '0;
                  state_nxt = S_FIND_RD;
                end
              end
              KIND_CLEAR: begin
                count_nxt = '0;
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_FIND_RD: begin
        mem_raddr = pos_r[AW-1:0];
        state_nxt = S_FIND_CMP;
      end

      S_FIND_CMP: begin
        // Pop takes the head without looking at the id.
        if (kind_r == KIND_POP || cmp_flags.id_eq) begin
          if (kind_r == KIND_POP) begin
            pop_id_nxt  = mem_rdata.id;
            pop_pri_nxt = mem_rdata.pri;
          end
          state_nxt = (kind_r == KIND_QUERY) ? S_RESP : S_SHL_RD;
        end else if (pos_p1 == count_r) begin
          stat_nxt  = STAT_MISS;
          state_nxt = S_RESP;
        end else begin
          pos_nxt   = pos_p1;
          state_nxt = S_FIND_RD;
        end
      end

      S_INS_RD: begin
        mem_raddr = pos_m1[AW-1:0];
        state_nxt = S_INS_CMP;
      end

      S_INS_CMP: begin
        // Move a lower-priority entry one slot toward the tail.
        if (cmp_flags.pri_lt) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[AW-1:0];
          mem_wdata = mem_rdata;
          pos_nxt   = pos_m1;
          state_nxt = (pos_m1 == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = cmp_key;
        count_nxt = count_r + 1'b1;
        state_nxt = S_RESP;
      end

      S_SHL_RD: begin
        if (pos_p1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end else begin
          mem_raddr = pos_p1[AW-1:0];
          state_nxt = S_SHL_WR;
        end
      end

      S_SHL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = mem_rdata;
        pos_nxt   = pos_p1;
        state_nxt = S_SHL_RD;
      end

      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = stat_r;
          out_object_nxt   = pop_id_r;
          out_priority_nxt = pop_pri_r;
          out_count_nxt    = COUNT_W'(count_r);
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Clear, null id, full queue, unused kinds, and remove, query or pop on an empty queue go
// straight to the response. Insert moves each lower-priority entry one slot toward the tail;
// query stops at the hit slot; remove and pop close the gap behind the hit.
// One request at a time: the next is taken once the response is raised; its own response
// waits while an older response is still held. Reset (synchronous, rst_n low) empties the
// queue, returns the sequencer to idle and drops a held response; the store is not cleared.
//
// Top level: instantiates the entry store, the compare unit and the sequencer.
// Depends on spq_pkg, spq_if, spq_mem, spq_cmp and spq_seq.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_req,
  spq_out_if.source out_rsp
);

  localparam int unsigned AW = $clog2(DEPTH);

  // Store port: one write and one read per cycle, read data registered.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // The one comparator, fed by the store read data and the held request.
  entry_t        cmp_key;
  cmp_flags_t    cmp_flags;

  spq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spq_cmp u_cmp (
    .stored (mem_rdata),
    .key    (cmp_key),
    .flags  (cmp_flags)
  );

  // Search scans from the head; insert scans from the tail and shifts as it
  // goes; remove and pop close the gap by moving later entries up one slot.
  spq_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_key   (cmp_key),
    .cmp_flags (cmp_flags)
  );

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [ID_W-1:0]     out_object,
  input logic [PRI_W-1:0]    out_priority,
  input logic [COUNT_W-1:0]  out_count
);

  localparam logic [COUNT_W-1:0] DEPTH_LOW = COUNT_W'(DEPTH);

  // Hold a pending response until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped before taken");

  // One request at a time: no request is taken in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // Popped fields are zero unless the operation succeeded.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_object == '0 && out_priority == '0)
    else $error("popped fields set on a failed request");

  // A full report comes only with a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_count == DEPTH_LOW)
    else $error("full status with a queue that is not full");

  // The count never exceeds the capacity (checked only for DEPTH up to 127).
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 127) || (out_count <= DEPTH_LOW))
    else $error("entry count above capacity");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH (DEPTH)
) u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_status   (out_rsp.status),
  .out_object   (out_rsp.out_object),
  .out_priority (out_rsp.out_priority),
  .out_count    (out_rsp.entry_count)
);
